### sv/lsr_pkg.sv
// Shared types and constants for the level set reinitialisation step.
// No dependencies; lsr_div, lsr_sqrt and the top level import this package.
`default_nettype none
package lsr_pkg;

  localparam int FRAC_BITS = 16;
  localparam int WORD_BITS = 32;
  localparam int SP_W      = 31;
  localparam int NUM_W     = 82;
  localparam int DEN_W     = 63;
  localparam int QUO_W     = 62;
  localparam int DIV_CNT_W = $clog2(NUM_W);
  localparam int ROOT_W    = 40;
  localparam int RAD_W     = 2 * ROOT_W;
  localparam int SQ_CNT_W  = $clog2(ROOT_W);

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;
  localparam logic [1:0] AXIS_NONE = 2'd3;

  localparam logic [1:0] REG_SPACING_X = 2'd0;
  localparam logic [1:0] REG_SPACING_Y = 2'd1;
  localparam logic [1:0] REG_SPACING_Z = 2'd2;

  typedef struct packed {
    logic [1:0]                  axis;
    logic signed [WORD_BITS-1:0] f_center;
    logic signed [WORD_BITS-1:0] f_fwd;
    logic signed [WORD_BITS-1:0] f_fwd2;
    logic signed [WORD_BITS-1:0] f_back;
    logic signed [WORD_BITS-1:0] f_back2;
    logic                        cut_fwd;
    logic                        cut_back;
    logic [SP_W-1:0]             dist_fwd;
    logic [SP_W-1:0]             dist_back;
    logic                        inside_req;
    logic [SP_W-1:0]             time_step;
  } lsr_in_t;

  typedef struct packed {
    logic signed [WORD_BITS-1:0] step_value;
  } lsr_out_t;

  typedef struct packed {
    logic [1:0]      index;
    logic [SP_W-1:0] value;
  } lsr_cfg_t;

endpackage
`default_nettype wire

### sv/lsr_chan_if.sv
// Valid/ready channel carrying one payload type.
// Depends on nothing; payload types come from lsr_pkg at instantiation.
`default_nettype none
interface lsr_chan_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

### sv/lsr_div.sv
// Restoring divider, one quotient bit a cycle, quotient capped at 2^61.
// Depends on lsr_pkg.
`default_nettype none
module lsr_div (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  input  wire logic [lsr_pkg::NUM_W-1:0] num_i,
  input  wire logic [lsr_pkg::DEN_W-1:0] den_i,
  output logic                           done_o,
  output logic [lsr_pkg::QUO_W-1:0]      quo_o
);
  import lsr_pkg::*;

  logic [NUM_W-1:0]     num_q, quo_q;
  logic [DEN_W-1:0]     den_q, rem_q, rem_d;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic                 busy_q, done_q;
  logic [DEN_W:0]       trial;
  logic                 ge;

  assign trial = {rem_q, num_q[NUM_W-1]};
  assign ge    = trial >= {1'b0, den_q};
  assign rem_d = ge ? DEN_W'(trial - {1'b0, den_q}) : DEN_W'(trial);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_q <= '0; quo_q <= '0; den_q <= '0; rem_q <= '0;
      cnt_q <= '0; busy_q <= 1'b0; done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        num_q  <= num_i;
        den_q  <= den_i;
        rem_q  <= '0;
        quo_q  <= '0;
        cnt_q  <= DIV_CNT_W'(NUM_W - 1);
        busy_q <= 1'b1;
      end else if (busy_q) begin
        num_q <= num_q << 1;
        rem_q <= rem_d;
        quo_q <= {quo_q[NUM_W-2:0], ge};
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  // anything at or above 2^61 reads as 2^61
  assign quo_o  = (|quo_q[NUM_W-1:QUO_W-1]) ? {1'b1, {(QUO_W-1){1'b0}}}
                                            : quo_q[QUO_W-1:0];
endmodule
`default_nettype wire

### sv/lsr_sqrt.sv
// Bit-serial integer square root, one root bit a cycle (floor of the root).
// Depends on lsr_pkg.
`default_nettype none
module lsr_sqrt (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [lsr_pkg::RAD_W-1:0]  rad_i,
  output logic                            done_o,
  output logic [lsr_pkg::ROOT_W-1:0]      root_o
);
  import lsr_pkg::*;

  logic [RAD_W-1:0]    rad_q;
  logic [ROOT_W+1:0]   rem_q, cur, trial, rem_d;
  logic [ROOT_W-1:0]   root_q;
  logic [SQ_CNT_W-1:0] cnt_q;
  logic                busy_q, done_q, ge;

  assign cur   = {rem_q[ROOT_W-1:0], rad_q[RAD_W-1 -: 2]};
  assign trial = {root_q, 2'b01};
  assign ge    = cur >= trial;
  assign rem_d = ge ? cur - trial : cur;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rad_q <= '0; rem_q <= '0; root_q <= '0;
      cnt_q <= '0; busy_q <= 1'b0; done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        rad_q  <= rad_i;
        rem_q  <= '0;
        root_q <= '0;
        cnt_q  <= SQ_CNT_W'(ROOT_W - 1);
        busy_q <= 1'b1;
      end else if (busy_q) begin
        rad_q  <= rad_q << 2;
        rem_q  <= rem_d;
        root_q <= {root_q[ROOT_W-2:0], ge};
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;
endmodule
`default_nettype wire

### sv/level_set_reinit_step.sv
// Top level: node-local level set reinitialisation step (ENO2, Godunov upwind).
// Depends on lsr_pkg, lsr_chan_if, lsr_div and lsr_sqrt.
//
//  channel  dir  payload    notes
//  in_i     in   lsr_in_t   one item per axis, x then y then z
//  res_o    out  lsr_out_t  one item per z input item
//  cfg_i    in   lsr_cfg_t  spacing registers 0..2, always ready
//
// Flow: one item is held from acceptance until done; the shared divider
// dominates, each division running through 82 quotient bits between its
// start and hand-off. An axis item runs one division per side plus one more
// for each cut side; a z item adds the square root and output. Reset returns
// spacings to 1.0 and clears the sum.
// A stalled result sits in the output register; a later z item waits in the output state.
`default_nettype none
module level_set_reinit_step (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  lsr_chan_if.sink   in_i,
  lsr_chan_if.source res_o,
  lsr_chan_if.sink   cfg_i
);
  import lsr_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_HH, S_D1, S_D1W, S_D2, S_D2W, S_SIDE,
    S_SQ, S_ACC, S_RT, S_RTW, S_DT, S_OUT
  } state_e;

  localparam logic signed [63:0] WMAX = 64'sd2147483647;
  localparam logic signed [63:0] WMIN = -64'sd2147483648;

  state_e          state_q;
  lsr_in_t         item_q;
  lsr_in_t         din;
  lsr_cfg_t        cfg;
  logic [SP_W-1:0] sp_x_q, sp_y_q, sp_z_q, h_sel, h_q;
  logic [61:0]     hh_q;
  logic            sd_q;
  logic signed [63:0] acc_q;
  logic signed [WORD_BITS-1:0] r_q, l_q;
  logic [72:0]     prod_q, prod;
  logic [63:0]     sum_q;
  logic            out_valid_q;
  logic signed [WORD_BITS-1:0] out_data_q;

  function automatic logic signed [34:0] minmod(logic signed [34:0] a,
                                                logic signed [34:0] b);
    logic signed [34:0] m;
    m = '0;
    if (a > 0 && b > 0) m = (a < b) ? a : b;
    else if (a < 0 && b < 0) m = (a > b) ? a : b;
    return m;
  endfunction

  // stencil and one-sided terms
  logic signed [34:0] c, ff, ff2, fb, fb2, p2, mmf, mmb, mm_sel;
  logic signed [35:0] n1;
  logic [35:0]        mag1;
  logic [34:0]        mmag;
  logic               cut_sel, neg1;
  logic [SP_W-1:0]    df, db, d_sel;
  logic [NUM_W-1:0]   num1, num2;
  logic [DEN_W-1:0]   den1;

  assign din = in_i.data;
  assign cfg = cfg_i.data;

  assign c   = 35'(item_q.f_center);
  assign ff  = 35'(item_q.f_fwd);
  assign ff2 = 35'(item_q.f_fwd2);
  assign fb  = 35'(item_q.f_back);
  assign fb2 = 35'(item_q.f_back2);
  assign p2  = ff + fb - c - c;
  assign mmf = minmod(p2, c + ff2 - ff - ff);
  assign mmb = minmod(p2, c + fb2 - fb - fb);

  assign df = (item_q.dist_fwd  == '0) ? SP_W'(1) : item_q.dist_fwd;
  assign db = (item_q.dist_back == '0) ? SP_W'(1) : item_q.dist_back;
  assign cut_sel = sd_q ? item_q.cut_back : item_q.cut_fwd;
  assign d_sel   = sd_q ? db : df;
  assign mm_sel  = sd_q ? mmb : mmf;
  assign mmag    = mm_sel[34] ? 35'(-mm_sel) : 35'(mm_sel);

  // first quotient: cut side uses -c/d (fwd) or c/d (back), else the ENO slope
  always_comb begin
    if (cut_sel) n1 = sd_q ? 36'(c) : -36'(c);
    else if (sd_q) n1 = 36'(c - fb) + 36'(c - fb) + 36'(mmb);
    else n1 = 36'(ff - c) + 36'(ff - c) - 36'(mmf);
  end
  assign neg1 = n1[35];
  assign mag1 = neg1 ? 36'(-n1) : 36'(n1);
  assign num1 = cut_sel ? NUM_W'({mag1, 16'b0}) : NUM_W'({mag1, 15'b0});
  assign den1 = cut_sel ? DEN_W'(d_sel) : DEN_W'(h_q);
  assign num2 = {prod_q[66:0], 15'b0};

  // shared divider, and the square root unit
  logic             div_start, div_done, sq_start, sq_done;
  logic [QUO_W-1:0] quo;
  logic [ROOT_W-1:0] root;
  logic signed [63:0] q_s;

  assign div_start = (state_q == S_D1) || (state_q == S_D2);
  assign sq_start  = (state_q == S_RT);

  lsr_div u_div (
    .clk_i, .rst_ni,
    .start_i (div_start),
    .num_i   ((state_q == S_D2) ? num2 : num1),
    .den_i   ((state_q == S_D2) ? DEN_W'(hh_q) : den1),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  lsr_sqrt u_sqrt (
    .clk_i, .rst_ni,
    .start_i (sq_start),
    .rad_i   ({sum_q, 16'b0}),
    .done_o  (sq_done),
    .root_o  (root)
  );

  assign q_s = signed'(64'(quo));

  // upwind selection
  logic signed [WORD_BITS-1:0] ls, rs, acc_sat;
  logic [WORD_BITS-1:0] ml, mr, m;
  always_comb begin
    if (item_q.inside_req) begin
      ls = (l_q < 0) ? l_q : '0;
      rs = (r_q > 0) ? r_q : '0;
    end else begin
      ls = (l_q > 0) ? l_q : '0;
      rs = (r_q < 0) ? r_q : '0;
    end
  end
  assign ml = ls[WORD_BITS-1] ? WORD_BITS'(-ls) : WORD_BITS'(ls);
  assign mr = rs[WORD_BITS-1] ? WORD_BITS'(-rs) : WORD_BITS'(rs);
  assign m  = (ml > mr) ? ml : mr;

  assign acc_sat = (acc_q > WMAX) ? WORD_BITS'(WMAX)
                 : (acc_q < WMIN) ? WORD_BITS'(WMIN) : WORD_BITS'(acc_q);

  // running sum, saturating; an x item restarts it
  logic [63:0] term, sum_d;
  logic [64:0] sum_w;
  assign term  = 64'(prod_q >> FRAC_BITS);
  assign sum_w = {1'b0, sum_q} + {1'b0, term};
  assign sum_d = (item_q.axis == AXIS_X) ? term
               : (sum_w[64] ? '1 : sum_w[63:0]);

  // node end: (root - 1.0) * dt, capped, negated for an inside request
  logic        vneg, rneg;
  logic [40:0] vmag;
  logic [56:0] p_full;
  logic [WORD_BITS-1:0] p, res;
  assign vneg   = root < ROOT_W'(1 << FRAC_BITS);
  assign vmag   = vneg ? 41'(ROOT_W'(1 << FRAC_BITS) - root)
                       : 41'(root - ROOT_W'(1 << FRAC_BITS));
  assign p_full = prod_q[72:FRAC_BITS];
  assign p      = (p_full > 57'(33'h0_8000_0000)) ? 32'h8000_0000 : p_full[31:0];
  assign rneg   = vneg ^ item_q.inside_req;
  assign res    = rneg ? 32'(-p) : ((p == 32'h8000_0000) ? 32'h7fff_ffff : p);

  // shared multiplier
  logic [40:0] mul_a;
  logic [31:0] mul_b;
  always_comb begin
    case (state_q)
      S_HH:    begin mul_a = 41'(h_q);  mul_b = 32'(h_q); end
      S_D1:    begin mul_a = 41'(mmag); mul_b = 32'(d_sel); end
      S_SQ:    begin mul_a = 41'(m);    mul_b = m; end
      S_DT:    begin mul_a = vmag;      mul_b = 32'(item_q.time_step); end
      default: begin mul_a = '0;        mul_b = '0; end
    endcase
  end
  assign prod = 73'(mul_a) * 73'(mul_b);

  always_comb begin
    case (din.axis)
      AXIS_X:  h_sel = sp_x_q;
      AXIS_Y:  h_sel = sp_y_q;
      default: h_sel = sp_z_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      item_q      <= '0;
      sp_x_q      <= SP_W'(1 << FRAC_BITS);
      sp_y_q      <= SP_W'(1 << FRAC_BITS);
      sp_z_q      <= SP_W'(1 << FRAC_BITS);
      h_q         <= '0;
      hh_q        <= '0;
      sd_q        <= 1'b0;
      acc_q       <= '0;
      r_q         <= '0;
      l_q         <= '0;
      prod_q      <= '0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      if (cfg_i.valid) begin
        case (cfg.index)
          REG_SPACING_X: sp_x_q <= cfg.value;
          REG_SPACING_Y: sp_y_q <= cfg.value;
          REG_SPACING_Z: sp_z_q <= cfg.value;
          default: ;
        endcase
      end
      // the output state handles its own reload of the result register
      if (out_valid_q && res_o.ready && state_q != S_OUT) out_valid_q <= 1'b0;

      case (state_q)
        S_IDLE: begin
          if (in_i.valid && din.axis != AXIS_NONE) begin
            item_q  <= din;
            h_q     <= (h_sel == '0) ? SP_W'(1) : h_sel;
            sd_q    <= 1'b0;
            state_q <= S_HH;
          end
        end
        S_HH: begin
          hh_q    <= prod[61:0];
          state_q <= S_D1;
        end
        S_D1: begin
          prod_q  <= prod;          // |mm| * d for the cut correction
          state_q <= S_D1W;
        end
        S_D1W: begin
          if (div_done) begin
            acc_q   <= neg1 ? -q_s : q_s;
            state_q <= cut_sel ? S_D2 : S_SIDE;
          end
        end
        S_D2: state_q <= S_D2W;
        S_D2W: begin
          if (div_done) begin
            // forward side subtracts the correction, backward adds it
            if (mm_sel[34] ^ sd_q) acc_q <= acc_q + q_s;
            else acc_q <= acc_q - q_s;
            state_q <= S_SIDE;
          end
        end
        S_SIDE: begin
          if (sd_q) begin
            l_q     <= acc_sat;
            state_q <= S_SQ;
          end else begin
            r_q     <= acc_sat;
            sd_q    <= 1'b1;
            state_q <= S_D1;
          end
        end
        S_SQ: begin
          prod_q  <= prod;
          state_q <= S_ACC;
        end
        S_ACC: begin
          sum_q   <= sum_d;
          state_q <= (item_q.axis == AXIS_Z) ? S_RT : S_IDLE;
        end
        S_RT: state_q <= S_RTW;
        S_RTW: if (sq_done) state_q <= S_DT;
        S_DT: begin
          prod_q  <= prod;
          sum_q   <= '0;
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_q || res_o.ready) begin
            out_valid_q <= 1'b1;
            out_data_q  <= signed'(res);
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_i.ready            = (state_q == S_IDLE);
  assign cfg_i.ready           = 1'b1;
  assign res_o.valid           = out_valid_q;
  assign res_o.data.step_value = out_data_q;
endmodule
`default_nettype wire
